### hdl/twn_pkg.sv
// ============================================================================
// twn_pkg
// Shared constants and types of the text whitespace normalizer.
// ============================================================================
`default_nettype none

package twn_pkg;

    // Width of the pending run counters. The run counts are clamped at
    // 2^RUN_COUNT_BITS - 1, and never above the 16-bit result fields.
    localparam int RUN_COUNT_BITS = 16;
    localparam int CNT_W          = (RUN_COUNT_BITS < 16) ? RUN_COUNT_BITS : 16;
    localparam int COUNT_OUT_W    = 16;
    localparam int TAB_W          = 4;

    // Reset value of the tab width register.
    localparam logic [TAB_W-1:0] TAB_WIDTH_RESET = 4'd8;

    // Byte codes with special meaning.
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NONE  = 8'h00;

    // One input item.
    typedef struct packed {
        logic [7:0] input_byte;
        logic       has_byte;
        logic       end_of_file;
    } twn_item_t;

    // One result item.
    typedef struct packed {
        logic [COUNT_OUT_W-1:0] blank_lines_before;
        logic [COUNT_OUT_W-1:0] spaces_before;
        logic [7:0]             out_char;
        logic                   char_present;
        logic                   stream_end;
        logic                   count_saturated;
    } twn_result_t;

endpackage

`default_nettype wire

### hdl/text_whitespace_normalizer_unit.sv
// ============================================================================
// text_whitespace_normalizer_unit
// Whitespace normalizer for a text byte stream with run-length coded output.
// ============================================================================
// The unit takes one byte per cycle while in_stall is low and gives at most
// one result per byte, registered in the result buffer; the only loop is the
// run counter and line state update. Carriage returns are dropped,
// spaces and tabs (tab_width spaces each) and blank lines are held as run
// counts and handed out in front of the next printable byte, and trailing
// whitespace and trailing blank lines never appear. End a stream with an
// end-only marker (has_byte low, end_of_file high) so an open line gets its
// closing line feed; that transfer always yields the final result. A
// two-entry result buffer lets input transfers continue while one result
// waits on out_stall; in_stall rises only when both entries are held. Write
// tab_width only while the unit is idle.
// ============================================================================
`default_nettype none

module text_whitespace_normalizer_unit (
    input  wire         clk,
    input  wire         rst_n,
    // Input channel
    input  wire         in_valid,
    output logic        in_stall,
    input  wire [7:0]   input_byte,
    input  wire         has_byte,
    input  wire         end_of_file,
    // Result channel
    output logic        out_valid,
    input  wire         out_stall,
    output logic [15:0] blank_lines_before,
    output logic [15:0] spaces_before,
    output logic [7:0]  out_char,
    output logic        char_present,
    output logic        stream_end,
    output logic        count_saturated,
    // Configuration write channel
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [3:0]   cfg_data
);
    import twn_pkg::*;

    logic        buf_full;
    logic        accept;
    logic        res_valid;
    twn_item_t   item;
    twn_result_t res;
    twn_result_t out_data;
    logic [TAB_W-1:0] tab_width_reg;

    assign in_stall  = buf_full;
    assign accept    = in_valid && !buf_full;
    assign cfg_ready = 1'b1;

    assign item.input_byte  = input_byte;
    assign item.has_byte    = has_byte;
    assign item.end_of_file = end_of_file;

    // Tab width register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_width_reg <= TAB_WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tab_width_reg <= cfg_data;
        end
    end

    // Line state and run counters.
    twn_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .tab_width (tab_width_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result buffer.
    twn_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign blank_lines_before = out_data.blank_lines_before;
    assign spaces_before      = out_data.spaces_before;
    assign out_char           = out_data.out_char;
    assign char_present       = out_data.char_present;
    assign stream_end         = out_data.stream_end;
    assign count_saturated    = out_data.count_saturated;

endmodule

`default_nettype wire

### hdl/twn_core.sv
// ============================================================================
// twn_core
// Holds the line state and run counters and turns one accepted byte into at
// most one result in the same cycle.
// ============================================================================
`default_nettype none

module twn_core (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  accept,
    input  twn_pkg::twn_item_t   item,
    input  wire [3:0]            tab_width,
    output logic                 res_valid,
    output twn_pkg::twn_result_t res
);
    import twn_pkg::*;

    logic [CNT_W-1:0] spaces_reg, spaces_next;
    logic [CNT_W-1:0] blanks_reg, blanks_next;
    logic             line_text_reg, line_text_next;
    logic             sat_reg, sat_next;

    // Saturating add of a small amount to a run counter. The top bit of the
    // returned value flags a clamp.
    function automatic logic [CNT_W:0] add_run(input logic [CNT_W-1:0] cnt,
                                               input logic [TAB_W-1:0] n);
        logic [CNT_W:0] sum;
        sum = {1'b0, cnt} + (CNT_W+1)'(n);
        if (sum[CNT_W])
        begin
            return {1'b1, {CNT_W{1'b1}}};
        end
        return {1'b0, sum[CNT_W-1:0]};
    endfunction

    // Next-state and result logic for one byte.
    always_comb
    begin
        logic [CNT_W:0] run;
        logic           done;
        logic           sat_work;

        spaces_next    = spaces_reg;
        blanks_next    = blanks_reg;
        line_text_next = line_text_reg;
        sat_work       = sat_reg;
        done           = 1'b0;
        run            = '0;
        res_valid      = 1'b0;
        res            = '0;

        if (item.has_byte)
        begin
            case (item.input_byte)
                CH_CR:
                begin
                    // Carriage returns are dropped.
                end
                CH_TAB:
                begin
                    run         = add_run(spaces_reg, tab_width);
                    spaces_next = run[CNT_W-1:0];
                    sat_work    = sat_work | run[CNT_W];
                end
                CH_SPACE:
                begin
                    run         = add_run(spaces_reg, TAB_W'(1));
                    spaces_next = run[CNT_W-1:0];
                    sat_work    = sat_work | run[CNT_W];
                end
                CH_LF:
                begin
                    spaces_next = '0;
                    if (line_text_reg)
                    begin
                        // End of a text line: emit the line feed.
                        line_text_next      = 1'b0;
                        res_valid           = 1'b1;
                        res.out_char        = CH_LF;
                        res.char_present    = 1'b1;
                        res.stream_end      = item.end_of_file;
                        res.count_saturated = sat_work;
                        sat_work            = 1'b0;
                        done                = 1'b1;
                    end
                    else
                    begin
                        // End of a blank line: count it.
                        run         = add_run(blanks_reg, TAB_W'(1));
                        blanks_next = run[CNT_W-1:0];
                        sat_work    = sat_work | run[CNT_W];
                    end
                end
                default:
                begin
                    // Printable byte with the held runs in front of it.
                    res_valid              = 1'b1;
                    res.blank_lines_before = COUNT_OUT_W'(blanks_reg);
                    res.spaces_before      = COUNT_OUT_W'(spaces_reg);
                    res.out_char           = item.input_byte;
                    res.char_present       = 1'b1;
                    res.stream_end         = item.end_of_file;
                    res.count_saturated    = sat_work;
                    sat_work               = 1'b0;
                    blanks_next            = '0;
                    spaces_next            = '0;
                    line_text_next         = 1'b1;
                    done                   = 1'b1;
                end
            endcase
        end

        // End of stream without a result yet: close an open line or mark end.
        if (item.end_of_file && !done)
        begin
            res_valid           = 1'b1;
            res.out_char        = line_text_reg ? CH_LF : CH_NONE;
            res.char_present    = line_text_reg;
            res.stream_end      = 1'b1;
            res.count_saturated = sat_work;
            sat_work            = 1'b0;
        end

        sat_next = sat_work;

        // After the final result all stream state returns to reset values.
        if (item.end_of_file)
        begin
            spaces_next    = '0;
            blanks_next    = '0;
            line_text_next = 1'b0;
            sat_next       = 1'b0;
        end
    end

    // State registers, updated on each accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spaces_reg    <= '0;
            blanks_reg    <= '0;
            line_text_reg <= 1'b0;
            sat_reg       <= 1'b0;
        end
        else if (accept)
        begin
            spaces_reg    <= spaces_next;
            blanks_reg    <= blanks_next;
            line_text_reg <= line_text_next;
            sat_reg       <= sat_next;
        end
    end

endmodule

`default_nettype wire

### hdl/twn_out_buf.sv
// ============================================================================
// twn_out_buf
// Two-entry result buffer: an output register backed by a skid register, so
// the input side never waits on the output stall within the same cycle.
// ============================================================================
`default_nettype none

module twn_out_buf (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  twn_pkg::twn_result_t push_data,
    output logic                 full,
    output logic                 out_valid,
    input  wire                  out_stall,
    output twn_pkg::twn_result_t out_data
);
    import twn_pkg::*;

    logic        out_valid_reg;
    twn_result_t out_data_reg;
    logic        skid_valid_reg;
    twn_result_t skid_data_reg;
    logic        pop;

    assign pop       = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
    end

    // The skid entry is only ever used behind a held output entry.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output entry");

    // No result arrives while the buffer is full.
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("result pushed into a full buffer");

    // A stalled result is not dropped.
    a_stalled_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result lost");

    // A result pushed behind a stalled one lands in the skid entry.
    a_push_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("result pushed behind a stalled one was lost");

endmodule

`default_nettype wire
